// ----- rtl/core/tca_pkg.sv -----
// Shared types and constants for the texel color adjust block.
// Depends on nothing; the front, back, top and testbench files import it.
package tca_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_AW      = 8;
    localparam int CFG_IW        = 3;
    localparam int CFG_DW        = 16;

    localparam logic [1:0] OP_PIXEL     = 2'd0;
    localparam logic [1:0] OP_WR_GAMMA  = 2'd1;
    localparam logic [1:0] OP_WR_INTENS = 2'd2;

    localparam logic [1:0] CLS_WALL = 2'd0;
    localparam logic [1:0] CLS_SKIN = 2'd1;

    localparam logic [1:0] LUT_NONE   = 2'd0;
    localparam logic [1:0] LUT_GAMMA  = 2'd1;
    localparam logic [1:0] LUT_INTENS = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_SAT_SCALE = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_LUMA_RED  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_LUMA_GRN  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_LUMA_BLU  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_HW_RAMP   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_GAMMA_PIC = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_INVERT    = 3'd6;

    localparam logic [8:0]  SCALE_ONE     = 9'd256;
    localparam logic [7:0]  COLOR_MAX     = 8'd255;
    localparam logic [8:0]  RST_SAT_SCALE = 9'd256;
    localparam logic [15:0] RST_LUMA_RED  = 16'd13933;
    localparam logic [15:0] RST_LUMA_GRN  = 16'd46871;
    localparam logic [15:0] RST_LUMA_BLU  = 16'd4732;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] texture_class;
        logic       turbulent;
        logic       last_pixel;
        logic [7:0] table_index;
        logic [7:0] table_value;
    } t_texel;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       out_last;
        logic       image_has_alpha;
    } t_result;

    typedef struct packed {
        logic [8:0]  saturation_scale;
        logic [15:0] luma_weight_red;
        logic [15:0] luma_weight_green;
        logic [15:0] luma_weight_blue;
        logic        hardware_gamma_ramp;
        logic        gamma_on_pictures;
        logic        invert_enable;
    } t_cfg;

    // Classified work item; table writes carry index in color[0], data in color[1].
    typedef struct packed {
        logic [1:0]      kind;
        logic [2:0][7:0] color;
        logic [7:0]      alpha;
        logic            last;
        logic            has_alpha;
        logic            desat;
        logic [1:0]      lut;
        logic            invert;
    } t_job;

endpackage

// ----- rtl/core/tca_fifo.sv -----
// Small register queue used between front and back and at the result side.
// Depends on nothing but its parameters.
module tca_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/tca_front.sv -----
// Front end: classifies accepted items and tracks the per-image alpha flag.
// Depends on tca_pkg.
module tca_front
    import tca_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_accept,
    input  t_texel i_texel,
    input  t_cfg   i_cfg,
    output logic   o_valid,
    output t_job   o_job
);

    logic r_alpha_seen;
    logic w_world;
    logic w_has_alpha;
    logic w_scale_one;

    assign w_world     = (i_texel.texture_class == CLS_WALL) && !i_texel.turbulent;
    assign w_has_alpha = r_alpha_seen || (i_texel.alpha != COLOR_MAX);
    assign w_scale_one = i_cfg.saturation_scale[8];

    always_comb begin
        o_job.kind      = i_texel.op;
        o_job.color[0]  = i_texel.red;
        o_job.color[1]  = i_texel.green;
        o_job.color[2]  = i_texel.blue;
        o_job.alpha     = i_texel.alpha;
        o_job.last      = i_texel.last_pixel;
        o_job.has_alpha = w_has_alpha;
        o_job.desat     = w_world && !w_scale_one;
        o_job.invert    = w_world && i_cfg.invert_enable;
        o_job.lut       = LUT_NONE;
        if (i_texel.op != OP_PIXEL) begin
            o_job.color[0] = i_texel.table_index;
            o_job.color[1] = i_texel.table_value;
            o_job.desat    = 1'b0;
        end
        if (!i_cfg.hardware_gamma_ramp) begin
            if (i_texel.texture_class == CLS_WALL || i_texel.texture_class == CLS_SKIN) begin
                o_job.lut = LUT_INTENS;
            end else if (i_cfg.gamma_on_pictures) begin
                o_job.lut = LUT_GAMMA;
            end
        end
    end

    // drop unknown ops here
    assign o_valid = i_accept && (i_texel.op == OP_PIXEL || i_texel.op == OP_WR_GAMMA ||
                                  i_texel.op == OP_WR_INTENS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_seen <= 1'b0;
        end else if (i_accept && i_texel.op == OP_PIXEL) begin
            r_alpha_seen <= i_texel.last_pixel ? 1'b0 : w_has_alpha;
        end
    end

endmodule

// ----- rtl/core/tca_back.sv -----
// Back end: desaturation pipeline, table lookup memories and inversion.
// Depends on tca_pkg.
module tca_back
    import tca_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_empty,
    input  t_job    i_job,
    output logic    o_q_pop,
    input  logic    i_out_full,
    output logic    o_out_push,
    output t_result o_result
);

    logic        w_adv;
    logic [8:0]  w_s;
    logic [8:0]  w_sinv;

    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    t_job        r_j1, r_j2, r_j3, r_j4, r_j5;
    logic [23:0] r_pr, r_pg, r_pb;
    logic [25:0] r_luma;
    logic [34:0] r_lw;
    logic [16:0] r_cs [3];
    t_job        w_j4;
    logic        w_pixel5;

    assign w_s    = i_cfg.saturation_scale[8] ? SCALE_ONE : i_cfg.saturation_scale;
    assign w_sinv = SCALE_ONE - w_s;

    assign w_pixel5 = r_v5 && (r_j5.kind == OP_PIXEL);
    assign w_adv    = !(w_pixel5 && i_out_full);
    assign o_q_pop  = w_adv && !i_q_empty;

    // blend toward luma and saturate
    always_comb begin
        logic [35:0] n;
        w_j4 = r_j3;
        for (int k = 0; k < 3; k++) begin
            n = 36'(r_lw) + {3'b000, r_cs[k], 16'h0000};
            if (r_j3.desat) begin
                w_j4.color[k] = (|n[35:32]) ? COLOR_MAX : n[31:24];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= o_q_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_j1   <= i_job;
            r_pr   <= i_cfg.luma_weight_red   * i_job.color[0];
            r_pg   <= i_cfg.luma_weight_green * i_job.color[1];
            r_pb   <= i_cfg.luma_weight_blue  * i_job.color[2];
            r_j2   <= r_j1;
            r_luma <= 26'(r_pr) + 26'(r_pg) + 26'(r_pb);
            r_j3   <= r_j2;
            r_lw   <= r_luma * w_sinv;
            for (int k = 0; k < 3; k++) begin
                r_cs[k] <= r_j2.color[k] * w_s;
            end
            r_j4   <= w_j4;
            r_j5   <= r_j4;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [7:0] r_gam [TABLE_ENTRIES];
        logic [7:0] r_int [TABLE_ENTRIES];
        logic [7:0] r_gq;
        logic [7:0] r_iq;
        logic [7:0] w_col;

        always_ff @(posedge i_clk) begin
            if (w_adv && r_v4 && r_j4.kind == OP_WR_GAMMA) begin
                r_gam[r_j4.color[0]] <= r_j4.color[1];
            end
            if (w_adv) begin
                r_gq <= r_gam[r_j4.color[k]];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv && r_v4 && r_j4.kind == OP_WR_INTENS) begin
                r_int[r_j4.color[0]] <= r_j4.color[1];
            end
            if (w_adv) begin
                r_iq <= r_int[r_j4.color[k]];
            end
        end

        always_comb begin
            case (r_j5.lut)
                LUT_GAMMA:  w_col = r_gq;
                LUT_INTENS: w_col = r_iq;
                default:    w_col = r_j5.color[k];
            endcase
            if (r_j5.invert) begin
                w_col = COLOR_MAX - w_col;
            end
        end
    end

    assign o_out_push              = w_pixel5 && !i_out_full;
    assign o_result.out_red        = g_lane[0].w_col;
    assign o_result.out_green      = g_lane[1].w_col;
    assign o_result.out_blue       = g_lane[2].w_col;
    assign o_result.out_alpha      = r_j5.alpha;
    assign o_result.out_last       = r_j5.last;
    assign o_result.image_has_alpha = r_j5.has_alpha;

endmodule

// ----- rtl/core/texel_color_adjust_top.sv -----
// Top level of the texel color adjust block: config registers, front, queues, back.
// Depends on tca_pkg, tca_fifo, tca_front and tca_back.
//
//   channel   | ports                               | accepted when
//   ----------+-------------------------------------+-----------------------
//   items in  | push, full, i_texel                 | push && !full
//   results   | empty, pop, o_result                | pop && !empty
//   config    | i_cfg_we, i_cfg_index, i_cfg_data   | i_cfg_we
//
// One item per clock sustained while the result queue has room. An accepted pixel
// passes the job queue, then multiply, luma sum, blend multiply, blend, table read
// and lookup select into the result queue. Table memories set the last two stages.
// Synchronous reset clears control state and config; table contents are undefined.
// The back pipeline holds as a whole while its finished pixel waits on a full result
// queue; the job queue keeps the front accepting until it fills.
module texel_color_adjust_top
    import tca_pkg::*;
#(
    parameter int JOB_DEPTH = 4,
    parameter int OUT_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_texel            i_texel,
    output logic              empty,
    input  logic              pop,
    output t_result           o_result,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    w_accept;
    logic    w_front_valid;
    t_job    w_front_job;
    logic    w_q_empty;
    t_job    w_q_job;
    logic    w_q_pop;
    logic    w_out_full;
    logic    w_out_push;
    t_result w_back_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.saturation_scale    <= RST_SAT_SCALE;
            r_cfg.luma_weight_red     <= RST_LUMA_RED;
            r_cfg.luma_weight_green   <= RST_LUMA_GRN;
            r_cfg.luma_weight_blue    <= RST_LUMA_BLU;
            r_cfg.hardware_gamma_ramp <= 1'b0;
            r_cfg.gamma_on_pictures   <= 1'b0;
            r_cfg.invert_enable       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAT_SCALE: r_cfg.saturation_scale    <= i_cfg_data[8:0];
                CFG_LUMA_RED:  r_cfg.luma_weight_red     <= i_cfg_data;
                CFG_LUMA_GRN:  r_cfg.luma_weight_green   <= i_cfg_data;
                CFG_LUMA_BLU:  r_cfg.luma_weight_blue    <= i_cfg_data;
                CFG_HW_RAMP:   r_cfg.hardware_gamma_ramp <= i_cfg_data[0];
                CFG_GAMMA_PIC: r_cfg.gamma_on_pictures   <= i_cfg_data[0];
                CFG_INVERT:    r_cfg.invert_enable       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_accept = push && !full;

    tca_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_texel (i_texel),
        .i_cfg   (r_cfg),
        .o_valid (w_front_valid),
        .o_job   (w_front_job)
    );

    tca_fifo #(
        .WIDTH($bits(t_job)),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_front_valid),
        .i_data (w_front_job),
        .o_full (full),
        .i_pop  (w_q_pop),
        .o_empty(w_q_empty),
        .o_data (w_q_job)
    );

    tca_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_q_empty),
        .i_job     (w_q_job),
        .o_q_pop   (w_q_pop),
        .i_out_full(w_out_full),
        .o_out_push(w_out_push),
        .o_result  (w_back_result)
    );

    tca_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_out_push),
        .i_data (w_back_result),
        .o_full (w_out_full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (o_result)
    );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for texel_color_adjust_top: directed table then randomized beats.
// Compares result queue output to directed rows' expected values or in-line predictions.
// Depends on tca_pkg and the texel_color_adjust_top RTL.
module tb;
    import tca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 300;

    typedef struct packed {
        t_texel  t;
        logic    typed;
        t_result want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    t_texel            i_texel = '0;
    logic              empty;
    logic              pop = 1'b0;
    t_result           o_result;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = CFG_SAT_SCALE;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    t_cfg       model_cfg;
    logic [7:0] gamma_lut [TABLE_ENTRIES];
    logic [7:0] intens_lut [TABLE_ENTRIES];
    logic       alpha_flag;

    t_result texels_due [$];
    t_row    rows [$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;
    int      sender_calm = 0;
    bit      hold_done = 1'b0;

    texel_color_adjust_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_texel     (i_texel),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_cfg mk_cfg(input logic [8:0] scale, input logic [15:0] wr,
                                    input logic [15:0] wg, input logic [15:0] wb,
                                    input logic hw, input logic gp, input logic inv);
        t_cfg c;
        c.saturation_scale    = scale;
        c.luma_weight_red     = wr;
        c.luma_weight_green   = wg;
        c.luma_weight_blue    = wb;
        c.hardware_gamma_ramp = hw;
        c.gamma_on_pictures   = gp;
        c.invert_enable       = inv;
        return c;
    endfunction

    function automatic t_texel px(input logic [1:0] op, input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input logic [7:0] a,
                                  input logic [1:0] cls, input logic turb, input logic last,
                                  input logic [7:0] idx, input logic [7:0] val);
        t_texel t;
        t.op            = op;
        t.red           = r;
        t.green         = g;
        t.blue          = b;
        t.alpha         = a;
        t.texture_class = cls;
        t.turbulent     = turb;
        t.last_pixel    = last;
        t.table_index   = idx;
        t.table_value   = val;
        return t;
    endfunction

    function automatic t_result res(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                                    input logic [7:0] a, input logic last, input logic has);
        t_result x;
        x.out_red         = r;
        x.out_green       = g;
        x.out_blue        = b;
        x.out_alpha       = a;
        x.out_last        = last;
        x.image_has_alpha = has;
        return x;
    endfunction

    function automatic bit adjust_texel(input t_texel t, output t_result r);
        logic [2:0][7:0] c;
        logic [8:0]      s;
        logic [63:0]     luma;
        logic [63:0]     n;
        bit              world;
        bit              seen;
        r = '0;
        if (t.op == OP_WR_GAMMA) begin
            gamma_lut[t.table_index] = t.table_value;
            return 1'b0;
        end
        if (t.op == OP_WR_INTENS) begin
            intens_lut[t.table_index] = t.table_value;
            return 1'b0;
        end
        if (t.op != OP_PIXEL) return 1'b0;
        c[0] = t.red;
        c[1] = t.green;
        c[2] = t.blue;
        world = (t.texture_class == CLS_WALL) && !t.turbulent;
        s = (model_cfg.saturation_scale > SCALE_ONE) ? SCALE_ONE : model_cfg.saturation_scale;
        luma = 64'(model_cfg.luma_weight_red) * 64'(t.red)
             + 64'(model_cfg.luma_weight_green) * 64'(t.green)
             + 64'(model_cfg.luma_weight_blue) * 64'(t.blue);
        for (int k = 0; k < 3; k++) begin
            if (world && s != SCALE_ONE) begin
                n = luma * (64'(SCALE_ONE) - 64'(s)) + (64'(c[k]) << 16) * 64'(s);
                c[k] = ((n >> 24) > 64'(COLOR_MAX)) ? COLOR_MAX : n[31:24];
            end
            if (!model_cfg.hardware_gamma_ramp) begin
                if (t.texture_class == CLS_WALL || t.texture_class == CLS_SKIN)
                    c[k] = intens_lut[c[k]];
                else if (model_cfg.gamma_on_pictures)
                    c[k] = gamma_lut[c[k]];
            end
            if (world && model_cfg.invert_enable) c[k] = COLOR_MAX - c[k];
        end
        seen = alpha_flag || (t.alpha != COLOR_MAX);
        alpha_flag = t.last_pixel ? 1'b0 : seen;
        r = res(c[0], c[1], c[2], t.alpha, t.last_pixel, seen);
        return 1'b1;
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_color();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return COLOR_MAX;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_texel random_texel();
        t_texel t;
        int     r;
        t = px(OP_PIXEL, rand_color(), rand_color(), rand_color(), COLOR_MAX,
               CLS_WALL, 1'b0, 1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        r = $urandom_range(0, 99);
        if (r < 7) t.op = OP_WR_GAMMA;
        else if (r < 12) t.op = OP_WR_INTENS;
        else if (r < 15) t.op = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) t.alpha = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        t.texture_class = (r < 5) ? CLS_WALL : 2'($urandom_range(0, 3));
        t.turbulent     = ($urandom_range(0, 2) == 0);
        t.last_pixel    = ($urandom_range(0, 9) == 0);
        return t;
    endfunction

    task automatic send_texel(input t_texel t, input bit typed, input t_result want);
        t_result r;
        int      gap;
        gap = pick_gap(sender_calm);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push    <= 1'b1;
        i_texel <= t;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (adjust_texel(t, r)) texels_due.push_back(typed ? want : r);
    endtask

    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (texels_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    task automatic run_phase(input t_cfg c, input int beats);
        settle();
        write_reg(CFG_SAT_SCALE, CFG_DW'(c.saturation_scale));
        write_reg(CFG_LUMA_RED, c.luma_weight_red);
        write_reg(CFG_LUMA_GRN, c.luma_weight_green);
        write_reg(CFG_LUMA_BLU, c.luma_weight_blue);
        write_reg(CFG_HW_RAMP, CFG_DW'(c.hardware_gamma_ramp));
        write_reg(CFG_GAMMA_PIC, CFG_DW'(c.gamma_on_pictures));
        write_reg(CFG_INVERT, CFG_DW'(c.invert_enable));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        model_cfg = c;
        repeat (beats) send_texel(random_texel(), 1'b0, '0);
    endtask

    // receiver: random stalls, one long hold-off to back up the input side
    initial begin : result_sink
        int stall;
        int calm;
        stall = 0;
        calm  = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                stall     = HOLD_LEN;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop   <= 1'b1;
                stall = pick_gap(calm);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (texels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_result);
            end else begin
                want = texels_due.pop_front();
                if (want.out_red !== o_result.out_red || want.out_green !== o_result.out_green
                    || want.out_blue !== o_result.out_blue
                    || want.out_alpha !== o_result.out_alpha
                    || want.out_last !== o_result.out_last
                    || want.image_has_alpha !== o_result.image_has_alpha) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch rgba %h %h %h %h last %b alpha %b, ",
                                  "got %h %h %h %h last %b alpha %b"},
                                 want.out_red, want.out_green, want.out_blue, want.out_alpha,
                                 want.out_last, want.image_has_alpha,
                                 o_result.out_red, o_result.out_green, o_result.out_blue,
                                 o_result.out_alpha, o_result.out_last,
                                 o_result.image_has_alpha);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL texel_color_adjust_top");
            $finish;
        end
    end

    initial begin : stimulus
        t_row row;
        model_cfg  = mk_cfg(RST_SAT_SCALE, RST_LUMA_RED, RST_LUMA_GRN, RST_LUMA_BLU,
                            1'b0, 1'b0, 1'b0);
        alpha_flag = 1'b0;

        rows.push_back({px(OP_PIXEL, 8'h00, 8'h00, 8'h00, COLOR_MAX, 2'd2, 1'b0, 1'b0,
                           8'hFF, 8'hFF), 1'b1, res(8'h00, 8'h00, 8'h00, COLOR_MAX, 1'b0, 1'b0)});
        rows.push_back({px(OP_PIXEL, COLOR_MAX, COLOR_MAX, COLOR_MAX, 8'h00, 2'd2, 1'b1, 1'b0,
                           8'h00, 8'h00), 1'b1, res(COLOR_MAX, COLOR_MAX, COLOR_MAX, 8'h00, 1'b0, 1'b1)});
        rows.push_back({px(OP_PIXEL, 8'h5A, 8'hA5, 8'h3C, COLOR_MAX, 2'd3, 1'b0, 1'b1,
                           8'h55, 8'hAA), 1'b1, res(8'h5A, 8'hA5, 8'h3C, COLOR_MAX, 1'b1, 1'b1)});
        rows.push_back({px(OP_PIXEL, 8'h01, 8'h02, 8'h03, COLOR_MAX, 2'd2, 1'b0, 1'b0,
                           8'hAA, 8'h55), 1'b1, res(8'h01, 8'h02, 8'h03, COLOR_MAX, 1'b0, 1'b0)});
        rows.push_back({px(2'd3, 8'h12, 8'h34, 8'h56, 8'h00, CLS_WALL, 1'b0, 1'b1,
                           8'h80, 8'h01), 1'b0, res(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0)});
        rows.push_back({px(OP_WR_INTENS, 8'h00, 8'h00, 8'h00, 8'h00, CLS_WALL, 1'b0, 1'b0,
                           8'h00, 8'h11), 1'b0, res(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0)});
        rows.push_back({px(OP_WR_INTENS, COLOR_MAX, COLOR_MAX, COLOR_MAX, COLOR_MAX, 2'd3, 1'b1,
                           1'b1, 8'hFF, 8'hEE), 1'b0, res(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0)});
        rows.push_back({px(OP_WR_INTENS, 8'h00, 8'h00, 8'h00, 8'h00, CLS_WALL, 1'b0, 1'b0,
                           8'h80, 8'h7F), 1'b0, res(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0)});
        rows.push_back({px(OP_WR_GAMMA, 8'h00, 8'h00, 8'h00, 8'h00, CLS_WALL, 1'b0, 1'b0,
                           8'h00, 8'hFF), 1'b0, res(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0)});
        rows.push_back({px(OP_WR_GAMMA, 8'h00, 8'h00, 8'h00, 8'h00, CLS_WALL, 1'b0, 1'b0,
                           8'hFF, 8'h00), 1'b0, res(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0)});
        rows.push_back({px(OP_PIXEL, 8'h00, COLOR_MAX, 8'h80, COLOR_MAX, CLS_SKIN, 1'b0, 1'b0,
                           8'h00, 8'h00), 1'b1, res(8'h11, 8'hEE, 8'h7F, COLOR_MAX, 1'b0, 1'b0)});
        rows.push_back({px(OP_PIXEL, COLOR_MAX, 8'h00, 8'h80, 8'hFE, CLS_WALL, 1'b1, 1'b1,
                           8'hFF, 8'hFF), 1'b1, res(8'hEE, 8'h11, 8'h7F, 8'hFE, 1'b1, 1'b1)});
        rows.push_back({px(OP_PIXEL, 8'h00, COLOR_MAX, 8'h00, COLOR_MAX, CLS_WALL, 1'b0, 1'b0,
                           8'h00, 8'h00), 1'b1, res(8'h11, 8'hEE, 8'h11, COLOR_MAX, 1'b0, 1'b0)});
        rows.push_back({px(OP_PIXEL, 8'h00, COLOR_MAX, 8'h00, COLOR_MAX, 2'd2, 1'b0, 1'b0,
                           8'h00, 8'h00), 1'b1, res(8'h00, COLOR_MAX, 8'h00, COLOR_MAX, 1'b0, 1'b0)});
        rows.push_back({px(2'd3, COLOR_MAX, COLOR_MAX, COLOR_MAX, COLOR_MAX, 2'd3, 1'b1, 1'b1,
                           8'hFF, 8'hFF), 1'b0, res(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0)});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            row = rows[k];
            send_texel(row.t, row.typed, row.want);
        end

        // load both tables completely before any random lookup
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            send_texel(px(OP_WR_GAMMA, 8'h00, 8'h00, 8'h00, COLOR_MAX, CLS_WALL, 1'b0, 1'b0,
                          8'(k), 8'($urandom_range(0, 255))), 1'b0, '0);
            send_texel(px(OP_WR_INTENS, 8'h00, 8'h00, 8'h00, COLOR_MAX, CLS_WALL, 1'b0, 1'b0,
                          8'(k), 8'($urandom_range(0, 255))), 1'b0, '0);
        end
        repeat (100) send_texel(random_texel(), 1'b0, '0);

        run_phase(mk_cfg(9'd0, RST_LUMA_RED, RST_LUMA_GRN, RST_LUMA_BLU, 1'b0, 1'b1, 1'b1), 110);
        run_phase(mk_cfg(9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0), 110);
        run_phase(mk_cfg(9'd128, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1), 110);
        run_phase(mk_cfg(9'($urandom_range(0, 256)), RST_LUMA_RED, RST_LUMA_GRN, RST_LUMA_BLU,
                         1'b1, 1'($urandom_range(0, 1)), 1'b1), 110);
        run_phase(mk_cfg(9'd257, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1), 110);
        run_phase(mk_cfg(SCALE_ONE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 1'b0, 1'b1, 1'b1), 110);
        repeat (3)
            run_phase(mk_cfg(9'($urandom_range(0, 511)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1))), 110);

        @(negedge i_clk);
        push <= 1'b0;
        while (texels_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && texels_due.size() == 0) begin
            $display("PASS texel_color_adjust_top");
        end else begin
            $display("FAIL texel_color_adjust_top");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tca_pkg.sv
rtl/core/tca_fifo.sv
rtl/core/tca_front.sv
rtl/core/tca_back.sv
rtl/core/texel_color_adjust_top.sv
dv/tb.sv
